// ===== hw/rtl/lphtu_pkg.sv =====
`timescale 1ns / 1ps

package lphtu_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 256;
  localparam int MAX_RESET_SIZE      = 256;

  localparam int VALUE_W  = 31;
  localparam int SIZE_W   = 9;
  localparam int SLOT_W   = 9;
  localparam int STATUS_W = 2;
  localparam int OP_W     = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUP     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

  localparam logic [SLOT_W-1:0] NO_SLOT = '1;

  typedef struct packed {
    logic               occ;
    logic [VALUE_W-1:0] value;
  } cell_t;

  typedef struct packed {
    logic  shift;
    logic  wr;
    cell_t wr_cell;
  } ring_ctl_t;

endpackage

// ===== hw/rtl/lphtu_cell.sv =====
`timescale 1ns / 1ps

module lphtu_cell
  import lphtu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  cell_t d,
  output cell_t q
);

  logic               occ;
  logic [VALUE_W-1:0] value;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (shift) begin
      occ <= d.occ;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      value <= d.value;
    end
  end

  assign q.occ   = occ;
  assign q.value = value;

endmodule

// ===== hw/rtl/lphtu_ctrl.sv =====
`timescale 1ns / 1ps

module lphtu_ctrl
  import lphtu_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     opcode,
  input  logic [VALUE_W-1:0]  item_value,
  output logic                done,
  output logic [SLOT_W-1:0]   slot_index,
  output logic [STATUS_W-1:0] status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SIZE_W-1:0]   table_size,
  input  cell_t               head,
  output ring_ctl_t           ring
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = ((IW > SLOT_W) ? IW : SLOT_W) + 1;
  localparam int BW = $clog2(VALUE_W);
  localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);
  localparam logic [BW-1:0] TOP_BIT = BW'(VALUE_W - 1);
  localparam logic [SIZE_W-1:0] SIZE_RST =
    SIZE_W'((TABLE_DEPTH < MAX_RESET_SIZE) ? TABLE_DEPTH : MAX_RESET_SIZE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_DECIDE,
    S_UPDATE
  } state_t;

  state_t              state;
  logic [SIZE_W-1:0]   size_reg;
  logic [OP_W-1:0]     op;
  logic [VALUE_W-1:0]  val;
  logic [SIZE_W-1:0]   n;
  logic [SIZE_W-1:0]   rem;
  logic [BW-1:0]       bitcnt;
  logic [IW-1:0]       cnt;
  logic                hit_f;
  logic [IW-1:0]       hit_idx;
  logic                fa_f;
  logic [IW-1:0]       fa_idx;
  logic                fb_f;
  logic [IW-1:0]       fb_idx;
  logic [IW-1:0]       target;

  logic [SIZE_W-1:0]   n_next;
  logic [SIZE_W:0]     rem_sh;
  logic [SIZE_W:0]     rem_sub;
  logic [SIZE_W-1:0]   rem_next;
  logic                in_use;
  logic                from_hash;
  logic                is_hit;
  logic                is_free;

  always_comb begin
    if (size_reg == '0) begin
      n_next = SIZE_W'(1);
    end else if (32'(size_reg) > TABLE_DEPTH) begin
      n_next = SIZE_W'(TABLE_DEPTH);
    end else begin
      n_next = size_reg;
    end
  end

  always_comb begin
    rem_sh   = {rem, val[bitcnt]};
    rem_sub  = (rem_sh >= {1'b0, n}) ? (rem_sh - {1'b0, n}) : rem_sh;
    rem_next = rem_sub[SIZE_W-1:0];
  end

  assign in_use    = CW'(cnt) < CW'(n);
  assign from_hash = CW'(cnt) >= CW'(rem);
  assign is_hit    = in_use && head.occ && (head.value == val);
  assign is_free   = in_use && !head.occ;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  assign ring.shift         = (state == S_SCAN) || (state == S_UPDATE);
  assign ring.wr            = (state == S_UPDATE) && (cnt == target);
  assign ring.wr_cell.occ   = (op == OP_INSERT);
  assign ring.wr_cell.value = val;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      size_reg <= table_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op     <= opcode;
            val    <= item_value;
            n      <= n_next;
            rem    <= '0;
            bitcnt <= TOP_BIT;
            state  <= S_MOD;
          end
        end
        S_MOD: begin
          rem    <= rem_next;
          bitcnt <= bitcnt - BW'(1);
          if (bitcnt == '0) begin
            cnt   <= '0;
            hit_f <= 1'b0;
            fa_f  <= 1'b0;
            fb_f  <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (is_hit && !hit_f) begin
            hit_f   <= 1'b1;
            hit_idx <= cnt;
          end
          if (is_free && !fa_f) begin
            fa_f   <= 1'b1;
            fa_idx <= cnt;
          end
          if (is_free && from_hash && !fb_f) begin
            fb_f   <= 1'b1;
            fb_idx <= cnt;
          end
          cnt <= cnt + IW'(1);
          if (cnt == LAST) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          cnt   <= '0;
          state <= S_IDLE;
          done  <= 1'b1;
          if (op == OP_INSERT) begin
            if (hit_f) begin
              slot_index <= NO_SLOT;
              status     <= STATUS_DUP;
            end else if (!fa_f) begin
              slot_index <= NO_SLOT;
              status     <= STATUS_FULL;
            end else begin
              target     <= fb_f ? fb_idx : fa_idx;
              slot_index <= SLOT_W'(CW'(fb_f ? fb_idx : fa_idx));
              status     <= STATUS_OK;
              done       <= 1'b0;
              state      <= S_UPDATE;
            end
          end else if (!hit_f) begin
            slot_index <= NO_SLOT;
            status     <= STATUS_MISSING;
          end else begin
            slot_index <= SLOT_W'(CW'(hit_idx));
            status     <= STATUS_OK;
            if (op == OP_REMOVE) begin
              target <= hit_idx;
              done   <= 1'b0;
              state  <= S_UPDATE;
            end
          end
        end
        S_UPDATE: begin
          cnt <= cnt + IW'(1);
          if (cnt == LAST) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/linear_probe_hash_table_unit.sv =====
`timescale 1ns / 1ps

// Channel    Handshake              Beat fields
// command    start / busy           opcode, item_value
// result     done (one cycle)       slot_index, status
// config     cfg_valid / cfg_ready  table_size
//
// Every operation first reduces item_value bit by bit modulo the size (zero
// read as one, capped at TABLE_DEPTH), then rotates the ring of TABLE_DEPTH
// cells once past the head to scan it. Search, and any operation that changes
// nothing, ends in the decide state after the scan; a successful insert or
// remove rotates the ring once more to write the head cell. Reset clears
// every occupied bit at once. The result beat is shown for one cycle and
// cannot be stalled.

module linear_probe_hash_table_unit
  import lphtu_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     opcode,
  input  logic [VALUE_W-1:0]  item_value,
  output logic                done,
  output logic [SLOT_W-1:0]   slot_index,
  output logic [STATUS_W-1:0] status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SIZE_W-1:0]   table_size
);

  cell_t     cells [TABLE_DEPTH];
  cell_t     tail_in;
  ring_ctl_t ring;

  lphtu_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .item_value (item_value),
    .done       (done),
    .slot_index (slot_index),
    .status     (status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .table_size (table_size),
    .head       (cells[0]),
    .ring       (ring)
  );

  // The head cell's contents return to the tail, replaced when written.
  assign tail_in = ring.wr ? ring.wr_cell : cells[0];

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    if (k == TABLE_DEPTH - 1) begin : g_tail
      lphtu_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (ring.shift),
        .d     (tail_in),
        .q     (cells[k])
      );
    end else begin : g_body
      lphtu_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (ring.shift),
        .d     (cells[k+1]),
        .q     (cells[k])
      );
    end
  end

endmodule

// ===== hw/rtl/lphtu_checker.sv =====
`timescale 1ns / 1ps

module lphtu_checker
  import lphtu_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [SLOT_W-1:0]   slot_index,
  input logic [STATUS_W-1:0] status
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command beat accepted but block not busy");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command beat");

  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result beat not at the end of an operation");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two result beats in a row");

  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    done && (status != STATUS_OK) |-> slot_index == NO_SLOT)
    else $error("failed operation reports a slot");

endmodule

bind linear_probe_hash_table_unit lphtu_checker u_lphtu_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .slot_index (slot_index),
  .status     (status)
);
